@@ rtl/lstm_pkg.sv @@
// lstm cell package: item types, opcodes, sequencer states, activation tables and helpers
// used by every module of the lstm cell forward core; no dependencies
`default_nettype none
package lstm_pkg;

    localparam int MAX_INPUT_DEF  = 64;
    localparam int MAX_HIDDEN_DEF = 64;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int VAL_W          = 16;
    localparam int ACC_W          = 48;

    typedef enum logic [2:0] {
        OP_IN_WEIGHT  = 3'd0,
        OP_REC_WEIGHT = 3'd1,
        OP_IN_BIAS    = 3'd2,
        OP_REC_BIAS   = 3'd3,
        OP_IN_ELEM    = 3'd4,
        OP_PREV_HID   = 3'd5,
        OP_PREV_CELL  = 3'd6,
        OP_RUN        = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        REG_INPUT_COUNT  = 2'd0,
        REG_HIDDEN_COUNT = 2'd1,
        REG_USE_IN_BIAS  = 2'd2,
        REG_USE_REC_BIAS = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [1:0]         gate;
        logic [5:0]         element;
        logic [5:0]         column;
        logic signed [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic [5:0]         unit;
        logic signed [15:0] hidden_out;
        logic signed [15:0] cell_out;
        logic               last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BIAS,
        ST_MAC_IN,
        ST_MAC_REC,
        ST_DRAIN,
        ST_ACT,
        ST_CELL_MUL,
        ST_CELL_SUM,
        ST_TANH_C,
        ST_HID_MUL,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic       mem_wr;
        logic [2:0] mem_sel;
        logic       acc_clear;
        logic       acc_en;
    } mem_ctl_t;

    function automatic logic [12:0] tanh_tab(input logic [5:0] k);
        logic [12:0] t;
        case (k)
            6'd0:  t = 13'd0;
            6'd1:  t = 13'd1003;
            6'd2:  t = 13'd1893;
            6'd3:  t = 13'd2602;
            6'd4:  t = 13'd3119;
            6'd5:  t = 13'd3475;
            6'd6:  t = 13'd3707;
            6'd7:  t = 13'd3856;
            6'd8:  t = 13'd3949;
            6'd9:  t = 13'd4006;
            6'd10: t = 13'd4041;
            6'd11: t = 13'd4062;
            6'd12: t = 13'd4076;
            6'd13: t = 13'd4084;
            6'd14: t = 13'd4089;
            6'd15: t = 13'd4091;
            6'd16: t = 13'd4093;
            6'd17: t = 13'd4094;
            6'd18: t = 13'd4095;
            6'd19: t = 13'd4095;
            default: t = 13'd4096;
        endcase
        return t;
    endfunction

    // magnitude up to 2^15
    function automatic logic [12:0] tanh_mag(input logic [15:0] m);
        logic [5:0]  i;
        logic [9:0]  r;
        logic [12:0] a;
        logic [12:0] b;
        logic [22:0] p;
        logic [12:0] t;
        i = {m[15], m[14:10]};
        r = m[9:0];
        a = tanh_tab(i);
        b = tanh_tab(i + 6'd1);
        p = 23'(b - a) * 23'(r) + 23'd512;
        t = a + 13'(p >> 10);
        if (m[15]) begin
            t = 13'd4096;
        end
        return t;
    endfunction

    function automatic logic signed [15:0] act_tanh(input logic signed [15:0] x);
        logic [15:0] m;
        logic [12:0] t;
        m = x[15] ? 16'(-17'(x)) : 16'(x);
        t = tanh_mag(m);
        return x[15] ? -16'(t) : 16'(t);
    endfunction

    function automatic logic signed [15:0] act_sigmoid(input logic signed [15:0] x);
        logic [15:0] m;
        logic [12:0] t;
        m = x[15] ? 16'(-17'(x)) : 16'(x);
        t = tanh_mag(m >> 1);
        return x[15] ? 16'((14'd4096 - 14'(t)) >> 1) : 16'((14'd4096 + 14'(t)) >> 1);
    endfunction

    function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] a,
                                                     input int vbits);
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        r  = (a + ACC_W'(2048)) >>> 12;
        hi = (ACC_W'(1) <<< (vbits - 1)) - ACC_W'(1);
        lo = -hi - ACC_W'(1);
        if (r > hi) begin
            r = hi;
        end else if (r < lo) begin
            r = lo;
        end
        return 16'(r);
    endfunction

endpackage
`default_nettype wire

@@ rtl/lstm_cell_forward_core.sv @@
// lstm cell forward core top level: item handshake, configuration registers and run sequencer
// depends on lstm_pkg and lstm_mem
`default_nettype none
// One forward LSTM cell step in signed Q4.12. Load items (op 0..6) write one weight, bias or
// vector entry each. A run item (op 7) walks every hidden unit in order: for each of the four
// gates it streams the input-weight row, then the recurrent-weight row, through a single
// multiply-accumulate fed by registered-read memories, one product a cycle, since each weight
// memory has one read port. Input and hidden counts are clamped to 1..MAX_INPUT and
// 1..MAX_HIDDEN, and a unit's result waits while the result channel still holds the last one.
// One result item per unit, last on the final unit. No item is accepted while a run is in
// progress. Memories are not cleared: entries read before being written give undefined results.
module lstm_cell_forward_core #(
    parameter int MAX_INPUT  = lstm_pkg::MAX_INPUT_DEF,
    parameter int MAX_HIDDEN = lstm_pkg::MAX_HIDDEN_DEF,
    parameter int DATA_WIDTH = lstm_pkg::DATA_WIDTH_DEF
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire  lstm_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire                       m_ready,
    output lstm_pkg::out_item_t       m_data,
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire  [1:0]                cfg_index,
    input  wire  [6:0]                cfg_data
);

    localparam int VBITS = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
    localparam int IW_AW = $clog2(4 * MAX_HIDDEN * MAX_INPUT);
    localparam int RW_AW = $clog2(4 * MAX_HIDDEN * MAX_HIDDEN);
    localparam int B_AW  = $clog2(4 * MAX_HIDDEN);
    localparam int X_AW  = (MAX_INPUT > 1) ? $clog2(MAX_INPUT) : 1;
    localparam int H_AW  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam int AW    = lstm_pkg::ACC_W;

    lstm_pkg::seq_state_t state_reg, state_next;
    logic [6:0] in_cnt_reg, hid_cnt_reg;
    logic       use_ib_reg, use_rb_reg;
    logic [8:0] ni, nh;

    logic [5:0] unit_reg, unit_next;
    logic [1:0] gate_reg, gate_next;
    logic [8:0] k_reg, k_next;
    logic       pend_reg, pend_next;
    logic [1:0] psel_reg, psel_next;

    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [15:0] ig_reg, ig_next, fg_reg, fg_next, cg_reg, cg_next, og_reg, og_next;
    logic signed [31:0] p1_reg, p1_next, p2_reg, p2_next;
    logic signed [15:0] c_reg, c_next, tc_reg, tc_next;
    logic               mvalid_reg, mvalid_next;
    lstm_pkg::out_item_t mdata_reg, mdata_next;

    logic signed [15:0] iw_q, rw_q, ib_q, rb_q, x_q, h_q, c_q;
    logic signed [15:0] wval;
    logic               s_fire;
    lstm_pkg::in_item_t in_it;
    logic               ld_ok;
    lstm_pkg::mem_ctl_t ctl;

    logic [IW_AW-1:0] rd_iw;
    logic [RW_AW-1:0] rd_rw;
    logic [B_AW-1:0]  rd_b;
    logic [X_AW-1:0]  rd_x;
    logic [H_AW-1:0]  rd_h;
    logic [H_AW-1:0]  rd_c;
    logic [IW_AW-1:0] wr_iw;
    logic [RW_AW-1:0] wr_rw;
    logic [B_AW-1:0]  wr_b;
    logic [B_AW-1:0]  row_b;

    assign ni = (in_cnt_reg == 7'd0) ? 9'd1 :
                (9'(in_cnt_reg) > 9'(MAX_INPUT)) ? 9'(MAX_INPUT) : 9'(in_cnt_reg);
    assign nh = (hid_cnt_reg == 7'd0) ? 9'd1 :
                (9'(hid_cnt_reg) > 9'(MAX_HIDDEN)) ? 9'(MAX_HIDDEN) : 9'(hid_cnt_reg);

    assign in_it     = s_data;
    assign s_ready   = (state_reg == lstm_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = mvalid_reg;
    assign m_data    = mdata_reg;
    assign wval      = 16'(signed'(in_it.value[VBITS-1:0]));

    always_comb begin
        ld_ok = 1'b0;
        case (lstm_pkg::op_t'(in_it.op))
            lstm_pkg::OP_IN_WEIGHT:
                ld_ok = (32'(in_it.element) < MAX_HIDDEN) && (32'(in_it.column) < MAX_INPUT);
            lstm_pkg::OP_REC_WEIGHT:
                ld_ok = (32'(in_it.element) < MAX_HIDDEN) && (32'(in_it.column) < MAX_HIDDEN);
            lstm_pkg::OP_IN_BIAS, lstm_pkg::OP_REC_BIAS, lstm_pkg::OP_PREV_HID,
            lstm_pkg::OP_PREV_CELL:
                ld_ok = 32'(in_it.element) < MAX_HIDDEN;
            lstm_pkg::OP_IN_ELEM:
                ld_ok = 32'(in_it.element) < MAX_INPUT;
            default: ld_ok = 1'b0;
        endcase
    end

    assign wr_b  = B_AW'(32'(in_it.gate) * MAX_HIDDEN + 32'(in_it.element));
    assign wr_iw = IW_AW'(32'(wr_b) * MAX_INPUT + 32'(in_it.column));
    assign wr_rw = RW_AW'(32'(wr_b) * MAX_HIDDEN + 32'(in_it.column));

    assign row_b = B_AW'(32'(gate_reg) * MAX_HIDDEN + 32'(unit_reg));
    assign rd_iw = IW_AW'(32'(row_b) * MAX_INPUT + 32'(k_reg));
    assign rd_rw = RW_AW'(32'(row_b) * MAX_HIDDEN + 32'(k_reg));
    assign rd_b  = row_b;
    assign rd_x  = X_AW'(k_reg);
    assign rd_h  = H_AW'(k_reg);
    assign rd_c  = H_AW'(unit_reg);

    assign ctl.mem_wr    = s_fire && ld_ok;
    assign ctl.mem_sel   = in_it.op;
    assign ctl.acc_clear = 1'b0;
    assign ctl.acc_en    = pend_reg;

    lstm_mem #(
        .MAX_INPUT (MAX_INPUT),
        .MAX_HIDDEN(MAX_HIDDEN),
        .IW_AW     (IW_AW),
        .RW_AW     (RW_AW),
        .B_AW      (B_AW),
        .X_AW      (X_AW),
        .H_AW      (H_AW)
    ) u_mem (
        .aclk      (aclk),
        .wr_en     (ctl.mem_wr),
        .wr_op     (ctl.mem_sel),
        .wr_iw_addr(wr_iw),
        .wr_rw_addr(wr_rw),
        .wr_b_addr (wr_b),
        .wr_x_addr (X_AW'(in_it.element)),
        .wr_h_addr (H_AW'(in_it.element)),
        .wr_data   (wval),
        .rd_iw_addr(rd_iw),
        .rd_rw_addr(rd_rw),
        .rd_b_addr (rd_b),
        .rd_x_addr (rd_x),
        .rd_h_addr (rd_h),
        .rd_c_addr (rd_c),
        .iw_q      (iw_q),
        .rw_q      (rw_q),
        .ib_q      (ib_q),
        .rb_q      (rb_q),
        .x_q       (x_q),
        .h_q       (h_q),
        .c_q       (c_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_cnt_reg  <= 7'd64;
            hid_cnt_reg <= 7'd64;
            use_ib_reg  <= 1'b1;
            use_rb_reg  <= 1'b1;
        end else if (cfg_valid) begin
            case (lstm_pkg::reg_idx_t'(cfg_index))
                lstm_pkg::REG_INPUT_COUNT:  in_cnt_reg  <= cfg_data;
                lstm_pkg::REG_HIDDEN_COUNT: hid_cnt_reg <= cfg_data;
                lstm_pkg::REG_USE_IN_BIAS:  use_ib_reg  <= cfg_data[0];
                lstm_pkg::REG_USE_REC_BIAS: use_rb_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= lstm_pkg::ST_IDLE;
            mvalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            pend_reg   <= pend_next;
        end
        unit_reg  <= unit_next;
        gate_reg  <= gate_next;
        k_reg     <= k_next;
        psel_reg  <= psel_next;
        acc_reg   <= acc_next;
        ig_reg    <= ig_next;
        fg_reg    <= fg_next;
        cg_reg    <= cg_next;
        og_reg    <= og_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        c_reg     <= c_next;
        tc_reg    <= tc_next;
        mdata_reg <= mdata_next;
    end

    always_comb begin
        logic signed [15:0] gs;
        logic signed [15:0] a;
        logic signed [15:0] b;
        state_next  = state_reg;
        unit_next   = unit_reg;
        gate_next   = gate_reg;
        k_next      = k_reg;
        pend_next   = 1'b0;
        psel_next   = psel_reg;
        acc_next    = acc_reg;
        ig_next     = ig_reg;
        fg_next     = fg_reg;
        cg_next     = cg_reg;
        og_next     = og_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        c_next      = c_reg;
        tc_next     = tc_reg;
        mvalid_next = mvalid_reg && !m_ready;
        mdata_next  = mdata_reg;
        gs          = '0;

        // product of the memory words read last cycle
        a = (psel_reg == 2'd0) ? x_q : h_q;
        b = (psel_reg == 2'd0) ? iw_q : rw_q;
        if (ctl.acc_en) begin
            acc_next = acc_reg + AW'(a) * AW'(b);
        end

        case (state_reg)
            lstm_pkg::ST_IDLE: begin
                if (s_fire && in_it.op == lstm_pkg::OP_RUN) begin
                    unit_next  = '0;
                    gate_next  = '0;
                    k_next     = '0;
                    state_next = lstm_pkg::ST_BIAS;
                end
            end
            lstm_pkg::ST_BIAS: begin
                // bias reads issued here, used in the following cycle by the first input step
                acc_next   = '0;
                k_next     = '0;
                state_next = lstm_pkg::ST_MAC_IN;
            end
            lstm_pkg::ST_MAC_IN: begin
                if (k_reg == 9'd0) begin
                    acc_next = (use_ib_reg ? (AW'(ib_q) <<< 12) : AW'(0)) +
                               (use_rb_reg ? (AW'(rb_q) <<< 12) : AW'(0));
                end
                pend_next = 1'b1;
                psel_next = 2'd0;
                if (k_reg + 9'd1 == ni) begin
                    k_next     = '0;
                    state_next = lstm_pkg::ST_MAC_REC;
                end else begin
                    k_next = k_reg + 9'd1;
                end
            end
            lstm_pkg::ST_MAC_REC: begin
                pend_next = 1'b1;
                psel_next = 2'd1;
                if (k_reg + 9'd1 == nh) begin
                    k_next     = '0;
                    state_next = lstm_pkg::ST_DRAIN;
                end else begin
                    k_next = k_reg + 9'd1;
                end
            end
            lstm_pkg::ST_DRAIN: begin
                state_next = lstm_pkg::ST_ACT;
            end
            lstm_pkg::ST_ACT: begin
                gs = lstm_pkg::round_sat(acc_reg, VBITS);
                case (gate_reg)
                    2'd0: ig_next = lstm_pkg::act_sigmoid(gs);
                    2'd1: fg_next = lstm_pkg::act_sigmoid(gs);
                    2'd2: cg_next = lstm_pkg::act_tanh(gs);
                    default: og_next = lstm_pkg::act_sigmoid(gs);
                endcase
                if (gate_reg == 2'd3) begin
                    state_next = lstm_pkg::ST_CELL_MUL;
                end else begin
                    gate_next  = gate_reg + 2'd1;
                    state_next = lstm_pkg::ST_BIAS;
                end
            end
            lstm_pkg::ST_CELL_MUL: begin
                p1_next    = fg_reg * c_q;
                p2_next    = ig_reg * cg_reg;
                state_next = lstm_pkg::ST_CELL_SUM;
            end
            lstm_pkg::ST_CELL_SUM: begin
                c_next     = lstm_pkg::round_sat(AW'(p1_reg) + AW'(p2_reg), VBITS);
                state_next = lstm_pkg::ST_TANH_C;
            end
            lstm_pkg::ST_TANH_C: begin
                tc_next    = lstm_pkg::act_tanh(c_reg);
                state_next = lstm_pkg::ST_HID_MUL;
            end
            lstm_pkg::ST_HID_MUL: begin
                p1_next    = og_reg * tc_reg;
                state_next = lstm_pkg::ST_EMIT;
            end
            lstm_pkg::ST_EMIT: begin
                if (!mvalid_reg || m_ready) begin
                    mvalid_next           = 1'b1;
                    mdata_next.unit       = unit_reg;
                    mdata_next.hidden_out = lstm_pkg::round_sat(AW'(p1_reg), VBITS);
                    mdata_next.cell_out   = c_reg;
                    mdata_next.last       = (9'(unit_reg) + 9'd1 == nh);
                    gate_next             = '0;
                    if (9'(unit_reg) + 9'd1 == nh) begin
                        state_next = lstm_pkg::ST_IDLE;
                    end else begin
                        unit_next  = unit_reg + 6'd1;
                        state_next = lstm_pkg::ST_BIAS;
                    end
                end
            end
            default: state_next = lstm_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/lstm_mem.sv @@
// lstm cell state memories: weights, biases and vectors, one registered read port each
// depends on lstm_pkg
`default_nettype none
module lstm_mem #(
    parameter int MAX_INPUT  = lstm_pkg::MAX_INPUT_DEF,
    parameter int MAX_HIDDEN = lstm_pkg::MAX_HIDDEN_DEF,
    parameter int IW_AW      = $clog2(4 * MAX_HIDDEN * MAX_INPUT),
    parameter int RW_AW      = $clog2(4 * MAX_HIDDEN * MAX_HIDDEN),
    parameter int B_AW       = $clog2(4 * MAX_HIDDEN),
    parameter int X_AW       = (MAX_INPUT > 1) ? $clog2(MAX_INPUT) : 1,
    parameter int H_AW       = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire  [2:0]               wr_op,
    input  wire  [IW_AW-1:0]         wr_iw_addr,
    input  wire  [RW_AW-1:0]         wr_rw_addr,
    input  wire  [B_AW-1:0]          wr_b_addr,
    input  wire  [X_AW-1:0]          wr_x_addr,
    input  wire  [H_AW-1:0]          wr_h_addr,
    input  wire  signed [15:0]       wr_data,
    input  wire  [IW_AW-1:0]         rd_iw_addr,
    input  wire  [RW_AW-1:0]         rd_rw_addr,
    input  wire  [B_AW-1:0]          rd_b_addr,
    input  wire  [X_AW-1:0]          rd_x_addr,
    input  wire  [H_AW-1:0]          rd_h_addr,
    input  wire  [H_AW-1:0]          rd_c_addr,
    output logic signed [15:0]       iw_q,
    output logic signed [15:0]       rw_q,
    output logic signed [15:0]       ib_q,
    output logic signed [15:0]       rb_q,
    output logic signed [15:0]       x_q,
    output logic signed [15:0]       h_q,
    output logic signed [15:0]       c_q
);

    logic signed [15:0] iw_mem [4*MAX_HIDDEN*MAX_INPUT];
    logic signed [15:0] rw_mem [4*MAX_HIDDEN*MAX_HIDDEN];
    logic signed [15:0] ib_mem [4*MAX_HIDDEN];
    logic signed [15:0] rb_mem [4*MAX_HIDDEN];
    logic signed [15:0] x_mem  [MAX_INPUT];
    logic signed [15:0] h_mem  [MAX_HIDDEN];
    logic signed [15:0] c_mem  [MAX_HIDDEN];

    always_ff @(posedge aclk) begin
        if (wr_en && wr_op == lstm_pkg::OP_IN_WEIGHT) begin
            iw_mem[wr_iw_addr] <= wr_data;
        end
        iw_q <= iw_mem[rd_iw_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_op == lstm_pkg::OP_REC_WEIGHT) begin
            rw_mem[wr_rw_addr] <= wr_data;
        end
        rw_q <= rw_mem[rd_rw_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_op == lstm_pkg::OP_IN_BIAS) begin
            ib_mem[wr_b_addr] <= wr_data;
        end
        ib_q <= ib_mem[rd_b_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_op == lstm_pkg::OP_REC_BIAS) begin
            rb_mem[wr_b_addr] <= wr_data;
        end
        rb_q <= rb_mem[rd_b_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_op == lstm_pkg::OP_IN_ELEM) begin
            x_mem[wr_x_addr] <= wr_data;
        end
        x_q <= x_mem[rd_x_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_op == lstm_pkg::OP_PREV_HID) begin
            h_mem[wr_h_addr] <= wr_data;
        end
        h_q <= h_mem[rd_h_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_op == lstm_pkg::OP_PREV_CELL) begin
            c_mem[wr_h_addr] <= wr_data;
        end
        c_q <= c_mem[rd_c_addr];
    end

endmodule
`default_nettype wire
